// ===== hdl/sig_pkg.sv =====
// Shared types and constants of the segment intersection graph.
// Depends on nothing; all but sig_ram and sig_fifo use its names.
`timescale 1ns / 1ps

package sig_pkg;

    localparam int COORD_W    = 25;
    localparam int INDEX_W    = 6;
    localparam int PAIR_W     = 11;
    localparam int CMD_DEPTH  = 2;
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

    typedef struct packed {
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        logic               new_set;
    } seg_t;

    typedef struct packed {
        logic [INDEX_W-1:0] new_index;
        logic [INDEX_W-1:0] earlier_index;
        logic               hit;
        logic [PAIR_W-1:0]  pair_total;
        logic               table_full;
        logic               last;
    } res_t;

    typedef enum logic {
        BK_IDLE,
        BK_SCAN
    } back_state_t;

endpackage

// ===== hdl/sig_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module sig_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sig_fifo.sv =====
// Small synchronous queue in flip-flops, with a fill count.
// Depends on nothing.
`timescale 1ns / 1ps

module sig_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== hdl/sig_front.sv =====
// Front end: takes segment requests, tracks the table fill and tags each
// request with its slot or a full mark. Depends on sig_pkg.
`timescale 1ns / 1ps

module sig_front #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 25,
    localparam int IW    = $clog2(MAX_SEGMENTS),
    localparam int CMD_W = 4 * COORD_BITS + IW + 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  sig_pkg::seg_t     segment,
    output logic              cmd_push,
    output logic [CMD_W-1:0]  cmd,
    input  logic              cmd_full
);

    localparam int CNTW = $clog2(MAX_SEGMENTS + 1);

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [IW-1:0]         index;
        logic                  full;
        logic                  new_set;
    } cmd_t;

    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] eff_count;
    logic            accept, is_full;
    logic [31:0]     sx_ext, sy_ext, ex_ext, ey_ext;
    cmd_t            c;

    assign full     = cmd_full;
    assign accept   = push && !cmd_full;
    assign cmd_push = accept;

    assign eff_count = segment.new_set ? '0 : count_reg;
    assign is_full   = (eff_count == CNTW'(MAX_SEGMENTS));

    assign sx_ext = 32'(segment.start_x);
    assign sy_ext = 32'(segment.start_y);
    assign ex_ext = 32'(segment.end_x);
    assign ey_ext = 32'(segment.end_y);

    always_comb
    begin
        c.sx      = sx_ext[COORD_BITS-1:0];
        c.sy      = sy_ext[COORD_BITS-1:0];
        c.ex      = ex_ext[COORD_BITS-1:0];
        c.ey      = ey_ext[COORD_BITS-1:0];
        c.index   = is_full ? '0 : eff_count[IW-1:0];
        c.full    = is_full;
        c.new_set = segment.new_set;
    end

    assign cmd = CMD_W'(c);

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            count_next = is_full ? eff_count : eff_count + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// ===== hdl/sig_back.sv =====
// Back end: scans the table one entry a cycle unless stalled, through a
// four-stage orientation pipeline; emits results. Uses sig_pkg, sig_ram.
`timescale 1ns / 1ps

module sig_back #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 25,
    localparam int IW    = $clog2(MAX_SEGMENTS),
    localparam int CMD_W = 4 * COORD_BITS + IW + 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [CMD_W-1:0]                cmd,
    input  logic                            cmd_empty,
    output logic                            cmd_pop,
    input  logic [sig_pkg::OUT_CNT_W-1:0]   out_count,
    output logic                            out_push,
    output sig_pkg::res_t                   out_res
);

    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int RW  = 4 * COORD_BITS;
    localparam int OCW = sig_pkg::OUT_CNT_W;

    typedef struct packed {
        logic [COORD_BITS-1:0] sx;
        logic [COORD_BITS-1:0] sy;
        logic [COORD_BITS-1:0] ex;
        logic [COORD_BITS-1:0] ey;
        logic [IW-1:0]         index;
        logic                  full;
        logic                  new_set;
    } cmd_t;

    cmd_t c;

    sig_pkg::back_state_t state_reg, state_next;

    logic [IW-1:0]             rd_idx_reg, rd_idx_next;
    logic [sig_pkg::PAIR_W-1:0] pair_reg, pair_next, pair_inc, pair_eff;
    logic                      pend_vld_reg, pend_vld_next;
    logic [IW-1:0]             pend_idx_reg, pend_idx_next;
    logic [sig_pkg::PAIR_W-1:0] pend_total_reg, pend_total_next;

    logic          v1_reg, v2_reg, v3_reg, v4_reg;
    logic [IW-1:0] idx1_reg, idx2_reg, idx3_reg, idx4_reg;
    logic          hit4_reg;

    logic signed [DW-1:0] abx_reg, aby_reg, cax_reg, cay_reg, dax_reg, day_reg;
    logic signed [DW-1:0] cdx_reg, cdy_reg, acx_reg, acy_reg, bcx_reg, bcy_reg;
    logic signed [PW-1:0] p_reg [4];
    logic signed [PW-1:0] q_reg [4];

    logic [RW-1:0]         rdata;
    logic                  ram_we;
    logic signed [DW-1:0]  ax, ay, bx, by, cx, cy, dx, dy;
    logic [2:0]            inflight;
    logic                  room, issue, drained, finish, hit_found, out_space;
    logic [3:0]            gt, lt;
    logic                  hit3;

    assign c = cmd_t'(cmd);

    sig_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_SEGMENTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (c.index),
        .wdata ({c.ey, c.ex, c.sy, c.sx}),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    assign inflight  = 3'(v1_reg) + 3'(v2_reg) + 3'(v3_reg) + 3'(v4_reg);
    assign room      = ((OCW + 1)'(out_count) + (OCW + 1)'(inflight))
                       <= (OCW + 1)'(sig_pkg::OUT_DEPTH - 2);
    assign out_space = (out_count != OCW'(sig_pkg::OUT_DEPTH));
    assign drained   = !(v1_reg || v2_reg || v3_reg || v4_reg);
    assign issue     = (state_reg == sig_pkg::BK_SCAN) && (rd_idx_reg != c.index) && room;
    assign finish    = (state_reg == sig_pkg::BK_SCAN) && (rd_idx_reg == c.index)
                       && drained && out_space;
    assign hit_found = v4_reg && hit4_reg;
    assign pair_inc  = (pair_reg == sig_pkg::PAIR_MAX) ? pair_reg : pair_reg + 1'b1;
    assign pair_eff  = c.new_set ? '0 : pair_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sig_pkg::BK_IDLE:
            begin
                if (!cmd_empty && !c.full)
                begin
                    state_next = sig_pkg::BK_SCAN;
                end
            end
            sig_pkg::BK_SCAN:
            begin
                if (finish)
                begin
                    state_next = sig_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = sig_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        cmd_pop         = 1'b0;
        out_push        = 1'b0;
        out_res         = '0;
        ram_we          = 1'b0;
        rd_idx_next     = rd_idx_reg;
        pair_next       = pair_reg;
        pend_vld_next   = pend_vld_reg;
        pend_idx_next   = pend_idx_reg;
        pend_total_next = pend_total_reg;
        case (state_reg)
            sig_pkg::BK_IDLE:
            begin
                if (!cmd_empty)
                begin
                    if (c.full)
                    begin
                        if (out_space)
                        begin
                            out_push             = 1'b1;
                            out_res.pair_total   = pair_eff;
                            out_res.table_full   = 1'b1;
                            out_res.last         = 1'b1;
                            pair_next            = pair_eff;
                            cmd_pop              = 1'b1;
                        end
                    end
                    else
                    begin
                        pair_next     = pair_eff;
                        rd_idx_next   = '0;
                        pend_vld_next = 1'b0;
                    end
                end
            end
            sig_pkg::BK_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
                // hold the newest hit; release the one before it
                if (hit_found)
                begin
                    pair_next       = pair_inc;
                    pend_vld_next   = 1'b1;
                    pend_idx_next   = idx4_reg;
                    pend_total_next = pair_inc;
                    if (pend_vld_reg)
                    begin
                        out_push              = 1'b1;
                        out_res.new_index     = sig_pkg::INDEX_W'(c.index);
                        out_res.earlier_index = sig_pkg::INDEX_W'(pend_idx_reg);
                        out_res.hit           = 1'b1;
                        out_res.pair_total    = pend_total_reg;
                    end
                end
                if (finish)
                begin
                    out_push          = 1'b1;
                    out_res.new_index = sig_pkg::INDEX_W'(c.index);
                    out_res.last      = 1'b1;
                    if (pend_vld_reg)
                    begin
                        out_res.earlier_index = sig_pkg::INDEX_W'(pend_idx_reg);
                        out_res.hit           = 1'b1;
                        out_res.pair_total    = pend_total_reg;
                    end
                    else
                    begin
                        out_res.pair_total = pair_reg;
                    end
                    ram_we        = 1'b1;
                    cmd_pop       = 1'b1;
                    pend_vld_next = 1'b0;
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    assign ax = $signed({1'b0, c.sx});
    assign ay = $signed({1'b0, c.sy});
    assign bx = $signed({1'b0, c.ex});
    assign by = $signed({1'b0, c.ey});
    assign cx = $signed({1'b0, rdata[COORD_BITS-1:0]});
    assign cy = $signed({1'b0, rdata[2*COORD_BITS-1:COORD_BITS]});
    assign dx = $signed({1'b0, rdata[3*COORD_BITS-1:2*COORD_BITS]});
    assign dy = $signed({1'b0, rdata[4*COORD_BITS-1:3*COORD_BITS]});

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            gt[k] = p_reg[k] > q_reg[k];
            lt[k] = p_reg[k] < q_reg[k];
        end
        hit3 = ((gt[0] && lt[1]) || (lt[0] && gt[1]))
               && ((gt[2] && lt[3]) || (lt[2] && gt[3]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sig_pkg::BK_IDLE;
            rd_idx_reg   <= '0;
            pair_reg     <= '0;
            pend_vld_reg <= 1'b0;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_idx_reg   <= rd_idx_next;
            pair_reg     <= pair_next;
            pend_vld_reg <= pend_vld_next;
            v1_reg       <= issue;
            v2_reg       <= v1_reg;
            v3_reg       <= v2_reg;
            v4_reg       <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg   <= pend_idx_next;
        pend_total_reg <= pend_total_next;
        idx1_reg       <= rd_idx_reg;
        idx2_reg       <= idx1_reg;
        idx3_reg       <= idx2_reg;
        idx4_reg       <= idx3_reg;

        abx_reg <= bx - ax;
        aby_reg <= by - ay;
        cax_reg <= cx - ax;
        cay_reg <= cy - ay;
        dax_reg <= dx - ax;
        day_reg <= dy - ay;
        cdx_reg <= dx - cx;
        cdy_reg <= dy - cy;
        acx_reg <= ax - cx;
        acy_reg <= ay - cy;
        bcx_reg <= bx - cx;
        bcy_reg <= by - cy;

        p_reg[0] <= PW'(abx_reg) * PW'(cay_reg);
        q_reg[0] <= PW'(cax_reg) * PW'(aby_reg);
        p_reg[1] <= PW'(abx_reg) * PW'(day_reg);
        q_reg[1] <= PW'(dax_reg) * PW'(aby_reg);
        p_reg[2] <= PW'(cdx_reg) * PW'(acy_reg);
        q_reg[2] <= PW'(acx_reg) * PW'(cdy_reg);
        p_reg[3] <= PW'(cdx_reg) * PW'(bcy_reg);
        q_reg[3] <= PW'(bcx_reg) * PW'(cdy_reg);

        hit4_reg <= hit3;
    end

endmodule

// ===== hdl/segment_intersection_graph.sv =====
// Top level of the segment intersection graph: front end, request queue, back end with
// segment table, result queue. Depends on sig_pkg and all sig_ modules but sig_checker.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------
//  segment   | push / full        | sig_pkg::seg_t   segment
//  result    | pop / empty        | sig_pkg::res_t   result
//
// In the back end a segment request reads the stored segments one table entry per cycle
// from the single RAM read port while the result queue has room, then the four-stage
// orientation pipeline drains. A request against a full table is answered without a scan.
// Reset clears the fill count, pair total and both queues; the table needs no clearing.
// A stalled result queue throttles the table scan; the request queue holds the stalled
// request and lets the front end accept one further segment meanwhile.
`timescale 1ns / 1ps

module segment_intersection_graph #(
    parameter int MAX_SEGMENTS = 64,
    parameter int COORD_BITS   = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  sig_pkg::seg_t segment,
    output logic          empty,
    input  logic          pop,
    output sig_pkg::res_t result
);

    localparam int IW    = $clog2(MAX_SEGMENTS);
    localparam int CMD_W = 4 * COORD_BITS + IW + 2;
    localparam int RES_W = $bits(sig_pkg::res_t);

    logic                          cmd_push, cmd_full, cmd_empty, cmd_pop;
    logic [CMD_W-1:0]              cmd_in, cmd_out;
    logic [$clog2(sig_pkg::CMD_DEPTH+1)-1:0] cmd_count;
    logic                          out_push, out_full;
    sig_pkg::res_t                 out_res;
    logic [RES_W-1:0]              res_bits;
    logic [sig_pkg::OUT_CNT_W-1:0] out_count;

    sig_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .segment  (segment),
        .cmd_push (cmd_push),
        .cmd      (cmd_in),
        .cmd_full (cmd_full)
    );

    sig_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (sig_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_push),
        .wdata (cmd_in),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .rdata (cmd_out),
        .empty (cmd_empty),
        .count (cmd_count)
    );

    sig_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COORD_BITS   (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_out),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_res   (out_res)
    );

    sig_fifo #(
        .WIDTH (RES_W),
        .DEPTH (sig_pkg::OUT_DEPTH)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (RES_W'(out_res)),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_bits),
        .empty (empty),
        .count (out_count)
    );

    assign result = sig_pkg::res_t'(res_bits);

endmodule

// ===== hdl/sig_checker.sv =====
// Port-level checks on the segment intersection graph, bound to the top level.
// Depends on sig_pkg and segment_intersection_graph.
`timescale 1ns / 1ps

module sig_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          push,
    input logic          full,
    input sig_pkg::seg_t segment,
    input logic          empty,
    input logic          pop,
    input sig_pkg::res_t result
);

    a_result_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

    a_full_form : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.table_full) |->
            (!result.hit && result.last && result.new_index == '0))
        else $error("malformed table-full result");

    a_miss_last : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.hit) |-> (result.last && result.earlier_index == '0))
        else $error("no-hit result not closing");

    a_hit_order : assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.hit) |->
            (result.earlier_index < result.new_index && !result.table_full))
        else $error("hit index out of order");

endmodule

bind segment_intersection_graph sig_checker u_sig_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .segment (segment),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for segment_intersection_graph: segment requests in, crossing
// reports out, checked against an in-bench crossing predictor or typed row answers.
// Depends on sig_pkg and the segment_intersection_graph RTL.
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_DEPTH    = 64;
    localparam int ITEM_TARGET    = 430;
    localparam int PAUSE_AT       = 320;
    localparam int HOLD_AFTER     = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [sig_pkg::COORD_W-1:0] CMAX  = '1;
    localparam logic [sig_pkg::COORD_W-1:0] ALT_A = 25'h1555555;
    localparam logic [sig_pkg::COORD_W-1:0] ALT_B = 25'h0AAAAAA;

    typedef struct packed {
        sig_pkg::seg_t seg;
        logic          typed;
        sig_pkg::res_t answer;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 17;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{'{0, 0, CMAX, CMAX, 1}, 1, '{0, 0, 0, 0, 0, 1}},
        '{'{0, CMAX, CMAX, 0, 0}, 1, '{1, 0, 1, 1, 0, 1}},
        '{'{CMAX, CMAX, CMAX, 0, 0}, 0, '0},
        '{'{1, 1, 7, 7, 0}, 0, '0},
        '{'{5, 5, 5, 5, 0}, 0, '0},
        '{'{100, 0, 100, 100, 0}, 0, '0},
        '{'{0, 20, CMAX, 20, 0}, 0, '0},
        '{'{ALT_A, ALT_B, ALT_B, ALT_A, 0}, 0, '0},
        '{'{CMAX, CMAX, CMAX, CMAX, 1}, 1, '{0, 0, 0, 0, 0, 1}},
        '{'{0, 0, CMAX, 0, 0}, 1, '{1, 0, 0, 0, 0, 1}},
        '{'{0, 0, CMAX, 0, 0}, 0, '0},
        '{'{CMAX, 0, 0, 0, 0}, 0, '0},
        '{'{0, CMAX, CMAX, CMAX, 0}, 0, '0},
        '{'{0, ALT_A, CMAX, ALT_B, 0}, 0, '0},
        '{'{ALT_A, 0, ALT_B, CMAX, 0}, 0, '0},
        '{'{0, 0, CMAX, CMAX, 1}, 1, '{0, 0, 0, 0, 0, 1}},
        '{'{0, CMAX, CMAX, 0, 0}, 1, '{1, 0, 1, 1, 0, 1}}
    };

    logic          clk;
    logic          rst_n;
    logic          push;
    logic          full;
    sig_pkg::seg_t segment;
    logic          empty;
    logic          pop;
    sig_pkg::res_t result;

    sig_pkg::seg_t held_segs [TABLE_DEPTH];
    int unsigned   held_count;
    int unsigned   pair_tally;
    sig_pkg::res_t pending_results [$];

    bit            seg_go;
    bit            res_go;
    bit            row_typed;
    sig_pkg::res_t row_answer;
    int            burst_left;
    int            items_taken;
    int            stall_cycles;
    int            error_count;
    bit            hold_done;

    segment_intersection_graph #(
        .MAX_SEGMENTS(TABLE_DEPTH),
        .COORD_BITS  (sig_pkg::COORD_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .segment(segment),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int orient(input longint ax, input longint ay, input longint bx,
                                  input longint by, input longint cx, input longint cy);
        longint p;
        longint q;
        p = (bx - ax) * (cy - ay);
        q = (cx - ax) * (by - ay);
        if (p > q)
            return 1;
        if (p < q)
            return -1;
        return 0;
    endfunction

    function automatic bit straddles(input sig_pkg::seg_t a, input sig_pkg::seg_t b);
        int s;
        int t;
        s = orient(64'(a.start_x), 64'(a.start_y), 64'(a.end_x), 64'(a.end_y),
                   64'(b.start_x), 64'(b.start_y));
        t = orient(64'(a.start_x), 64'(a.start_y), 64'(a.end_x), 64'(a.end_y),
                   64'(b.end_x), 64'(b.end_y));
        return (s * t) < 0;
    endfunction

    task automatic predict_crossings(input sig_pkg::seg_t s);
        sig_pkg::res_t r;
        sig_pkg::res_t prev;
        bit            have_prev;
        if (s.new_set)
        begin
            held_count = 0;
            pair_tally = 0;
        end
        r = '0;
        r.pair_total = sig_pkg::PAIR_W'(pair_tally);
        r.last = 1'b1;
        if (held_count >= TABLE_DEPTH)
        begin
            r.table_full = 1'b1;
            pending_results.push_back(r);
            return;
        end
        have_prev = 1'b0;
        prev = '0;
        for (int j = 0; j < held_count; j++)
        begin
            if (straddles(s, held_segs[j]) && straddles(held_segs[j], s))
            begin
                if (have_prev)
                    pending_results.push_back(prev);
                if (pair_tally < sig_pkg::PAIR_MAX)
                    pair_tally++;
                prev = '0;
                prev.new_index = sig_pkg::INDEX_W'(held_count);
                prev.earlier_index = sig_pkg::INDEX_W'(j);
                prev.hit = 1'b1;
                prev.pair_total = sig_pkg::PAIR_W'(pair_tally);
                have_prev = 1'b1;
            end
        end
        if (have_prev)
        begin
            prev.last = 1'b1;
            pending_results.push_back(prev);
        end
        else
        begin
            r.new_index = sig_pkg::INDEX_W'(held_count);
            pending_results.push_back(r);
        end
        held_segs[held_count] = s;
        held_count++;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        error_count++;
    endtask

    task automatic compare_result(input sig_pkg::res_t want, input sig_pkg::res_t got);
        if (got.new_index !== want.new_index)
            report_mismatch("new_index", 32'(want.new_index), 32'(got.new_index));
        if (got.earlier_index !== want.earlier_index)
            report_mismatch("earlier_index", 32'(want.earlier_index),
                            32'(got.earlier_index));
        if (got.hit !== want.hit)
            report_mismatch("hit", 32'(want.hit), 32'(got.hit));
        if (got.pair_total !== want.pair_total)
            report_mismatch("pair_total", 32'(want.pair_total), 32'(got.pair_total));
        if (got.table_full !== want.table_full)
            report_mismatch("table_full", 32'(want.table_full), 32'(got.table_full));
        if (got.last !== want.last)
            report_mismatch("last", 32'(want.last), 32'(got.last));
    endtask

    // sample at the falling edge: push, pop and the outputs are all settled here
    always @(negedge clk)
    begin : monitor
        sig_pkg::res_t want;
        int            queued;
        seg_go = rst_n && push && !full;
        res_go = rst_n && pop && !empty;
        if (seg_go)
        begin
            queued = pending_results.size();
            predict_crossings(segment);
            if (row_typed)
            begin
                while (pending_results.size() > queued)
                    want = pending_results.pop_back();
                pending_results.push_back(row_answer);
            end
            items_taken++;
        end
        if (res_go)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, result);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_result(want, result);
            end
        end
        if (seg_go || res_go || !rst_n)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_request(input stim_row_t row);
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 80 : $urandom_range(1, 20);
        end
        burst_left--;
        row_typed = row.typed;
        row_answer = row.answer;
        push <= 1'b1;
        segment <= row.seg;
        do @(posedge clk); while (!seg_go);
    endtask

    function automatic sig_pkg::seg_t draw_segment(input bit fresh,
                                                   input logic [sig_pkg::COORD_W-1:0] base);
        sig_pkg::seg_t s;
        int            style;
        style = $urandom_range(0, 9);
        if (style < 5)
        begin
            s.start_x = sig_pkg::COORD_W'($urandom_range(0, CMAX));
            s.start_y = sig_pkg::COORD_W'($urandom_range(0, CMAX));
            s.end_x = sig_pkg::COORD_W'($urandom_range(0, CMAX));
            s.end_y = sig_pkg::COORD_W'($urandom_range(0, CMAX));
        end
        else
        begin
            s.start_x = sig_pkg::COORD_W'(base + $urandom_range(0, 7));
            s.start_y = sig_pkg::COORD_W'(base + $urandom_range(0, 7));
            s.end_x = sig_pkg::COORD_W'(base + $urandom_range(0, 7));
            s.end_y = sig_pkg::COORD_W'(base + $urandom_range(0, 7));
        end
        if (style == 9)
        begin
            s.end_x = s.start_x;
            s.end_y = s.start_y;
        end
        s.new_set = fresh || ($urandom_range(0, 49) == 0);
        return s;
    endfunction

    initial
    begin : requests
        stim_row_t                   row;
        int                          items_sent;
        int                          set_no;
        int                          set_len;
        logic [sig_pkg::COORD_W-1:0] base;
        rst_n = 1'b0;
        push <= 1'b0;
        segment <= '0;
        held_count = 0;
        pair_tally = 0;
        burst_left = 0;
        error_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_request(DIRECTED[i]);
        items_sent = DIRECTED_ROWS;
        set_no = 0;
        row = '0;
        while (items_sent < ITEM_TARGET)
        begin
            // fill the table past its depth now and then
            if (set_no == 0 || set_no == 5 || $urandom_range(0, 9) == 0)
                set_len = TABLE_DEPTH + $urandom_range(1, 4);
            else
                set_len = $urandom_range(1, 24);
            base = sig_pkg::COORD_W'($urandom_range(0, CMAX - 8));
            for (int k = 0; k < set_len && items_sent < ITEM_TARGET; k++)
            begin
                row.seg = draw_segment(k == 0, base);
                send_request(row);
                items_sent++;
                if (items_sent == PAUSE_AT)
                begin
                    push <= 1'b0;
                    do @(posedge clk); while (pending_results.size() != 0);
                end
            end
            set_no++;
        end
        push <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : results
        int mode;
        int span;
        pop <= 1'b0;
        mode = 0;
        span = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && items_taken >= HOLD_AFTER)
            begin
                // hold off so the block backs up and stalls its input
                hold_done = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 2);
                    span = $urandom_range(4, 60);
                end
                span--;
                case (mode)
                    0: pop <= 1'b1;
                    1: pop <= ($urandom_range(0, 3) != 0);
                    default: pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

endmodule
